// ----- design/srlm_pkg.sv -----
package srlm_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CfgW   = 64;
  localparam int unsigned CountW = 4;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TOKEN_CHARS  = 3'd0,
    CFG_STAR_MASK    = 3'd1,
    CFG_ANY_MASK     = 3'd2,
    CFG_TOKEN_COUNT  = 3'd3,
    CFG_ANCHOR_START = 3'd4,
    CFG_ANCHOR_END   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [CfgW-1:0]   token_chars;
    logic [7:0]        star_mask;
    logic [7:0]        any_mask;
    logic [CountW-1:0] token_count;
    logic              anchor_start;
    logic              anchor_end;
  } cfg_t;

  typedef struct packed {
    logic match_seen;
    logic text_ended;
    logic at_line_start;
  } line_flags_t;

endpackage

// ----- design/simple_regex_line_matcher_unit.sv -----
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  in_text_byte, in_line_last
// out      output     out_valid/out_stall out_line_matched
// cfg      input      cfg_we             cfg_index, cfg_wdata
//
// One item per cycle is sustained while no held result stalls the input; a result passes the
// input register, then the result register, after the last byte of its line is accepted.
// The position update is a single combinational pass between those two registers.
// Reset (rst_n low at a clock edge) clears configuration and puts the matcher at line start.
// A held result stalls only the last byte of the next line; other bytes keep flowing.
module simple_regex_line_matcher_unit
  import srlm_pkg::*;
#(
  parameter int unsigned TOKENS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CfgW-1:0]  cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CharW-1:0] in_text_byte,
  input  logic             in_line_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_line_matched
);

  cfg_t             cfg;
  logic             inq_valid_r;
  logic             inq_valid_nxt;
  logic [CharW-1:0] inq_byte_r;
  logic             inq_last_r;
  logic [TOKENS:0]  active_r;
  logic [TOKENS:0]  active_nxt;
  line_flags_t      flags_r;
  line_flags_t      flags_nxt;
  logic             matched;
  logic             fire;
  logic             in_accept;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_matched_r;

  srlm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srlm_step #(
    .TOKENS (TOKENS)
  ) u_step (
    .cfg          (cfg),
    .active       (active_r),
    .flags        (flags_r),
    .text_byte    (inq_byte_r),
    .line_last    (inq_last_r),
    .active_nxt   (active_nxt),
    .flags_nxt    (flags_nxt),
    .line_matched (matched)
  );

  // The queued item is processed unless it produces a result and the result
  // register is still held.
  assign fire      = inq_valid_r && !(inq_last_r && out_valid_r && out_stall);
  assign in_stall  = inq_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  assign inq_valid_nxt = in_accept || (inq_valid_r && !fire);
  assign out_valid_nxt = (fire && inq_last_r) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= {{TOKENS{1'b0}}, 1'b1};
      flags_r     <= '{match_seen: 1'b0, text_ended: 1'b0, at_line_start: 1'b1};
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        active_r <= active_nxt;
        flags_r  <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      inq_byte_r <= in_text_byte;
      inq_last_r <= in_line_last;
    end
    if (fire && inq_last_r) begin
      out_matched_r <= matched;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_line_matched = out_matched_r;

endmodule

// ----- design/srlm_cfg.sv -----
module srlm_cfg
  import srlm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOKEN_CHARS:  cfg_r.token_chars  <= cfg_wdata;
        CFG_STAR_MASK:    cfg_r.star_mask    <= cfg_wdata[7:0];
        CFG_ANY_MASK:     cfg_r.any_mask     <= cfg_wdata[7:0];
        CFG_TOKEN_COUNT:  cfg_r.token_count  <= cfg_wdata[CountW-1:0];
        CFG_ANCHOR_START: cfg_r.anchor_start <= cfg_wdata[0];
        CFG_ANCHOR_END:   cfg_r.anchor_end   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/srlm_step.sv -----
module srlm_step
  import srlm_pkg::*;
#(
  parameter int unsigned TOKENS = 8
) (
  input  cfg_t               cfg,
  input  logic [TOKENS:0]    active,
  input  line_flags_t        flags,
  input  logic [CharW-1:0]   text_byte,
  input  logic               line_last,
  output logic [TOKENS:0]    active_nxt,
  output line_flags_t        flags_nxt,
  output logic               line_matched
);

  logic [CountW-1:0] used;
  logic [TOKENS:0]   start_set;
  logic [TOKENS:0]   act0;
  logic [TOKENS:0]   adv_set;
  logic [TOKENS:0]   act1;
  logic              ms0;
  logic              ms1;
  logic              ms2;
  logic              te0;
  logic              te1;

  // Positions reachable by skipping starred tokens.
  function automatic logic [TOKENS:0] closure(input logic [TOKENS:0] set,
                                              input logic [CountW-1:0] n,
                                              input logic [7:0] star);
    logic [TOKENS:0] s;
    s = set;
    for (int i = 0; i < TOKENS; i++) begin
      if ((CountW'(i) < n) && s[i] && star[i]) begin
        s[i+1] = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic logic final_set(input logic [TOKENS:0] set,
                                     input logic [CountW-1:0] n);
    logic f;
    f = 1'b0;
    for (int i = 0; i <= TOKENS; i++) begin
      if (CountW'(i) == n) begin
        f = set[i];
      end
    end
    return f;
  endfunction

  always_comb begin
    if (cfg.token_count > CountW'(TOKENS)) begin
      used = CountW'(TOKENS);
    end else begin
      used = cfg.token_count;
    end

    start_set = closure({{TOKENS{1'b0}}, 1'b1}, used, cfg.star_mask);

    // The first byte of a line starts from the start position.
    if (flags.at_line_start) begin
      act0 = start_set;
      ms0  = !cfg.anchor_end && final_set(start_set, used);
      te0  = 1'b0;
    end else begin
      act0 = active;
      ms0  = flags.match_seen;
      te0  = flags.text_ended;
    end

    adv_set = '0;
    for (int i = 0; i < TOKENS; i++) begin
      if ((CountW'(i) < used) && act0[i] &&
          (cfg.any_mask[i] || (cfg.token_chars[CharW*i +: CharW] == text_byte))) begin
        if (cfg.star_mask[i]) begin
          adv_set[i] = 1'b1;
        end else begin
          adv_set[i+1] = 1'b1;
        end
      end
    end
    if (!cfg.anchor_start) begin
      adv_set[0] = 1'b1;
    end

    act1 = act0;
    ms1  = ms0;
    te1  = te0;
    if (!te0) begin
      if (text_byte == '0) begin
        // A zero byte ends the text; an end anchor is checked here.
        ms1 = ms0 || (cfg.anchor_end && final_set(act0, used));
        te1 = 1'b1;
      end else begin
        act1 = closure(adv_set, used, cfg.star_mask);
        ms1  = ms0 || (!cfg.anchor_end && final_set(act1, used));
      end
    end

    ms2 = ms1;
    if (!te1) begin
      ms2 = ms1 || (cfg.anchor_end && final_set(act1, used));
    end
    line_matched = ms2;

    if (line_last) begin
      active_nxt              = start_set;
      flags_nxt.match_seen    = 1'b0;
      flags_nxt.text_ended    = 1'b0;
      flags_nxt.at_line_start = 1'b1;
    end else begin
      active_nxt              = act1;
      flags_nxt.match_seen    = ms1;
      flags_nxt.text_ended    = te1;
      flags_nxt.at_line_start = 1'b0;
    end
  end

endmodule
